// ===== src/eihp_pkg.sv =====
// eihp_pkg: shared types, constants and field lookup for the header parser
// no dependencies
package eihp_pkg;

    localparam int MaxFrameBytesDefault = 65535;
    localparam int QueueDepth = 4;

    localparam logic [15:0] EthertypeIpv4 = 16'h0800;
    localparam logic [15:0] MinFrameLen   = 16'd34;
    localparam logic [7:0]  ProtoTcp      = 8'd6;
    localparam logic [7:0]  ProtoUdp      = 8'd17;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_NOT_IPV4  = 3'd2,
        ST_BAD_IP    = 3'd3,
        ST_TOO_LONG  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        HE_NONE = 2'd0,
        HE_NOT_IPV4 = 2'd1,
        HE_BAD_IP = 2'd2
    } t_herr;

    localparam logic [4:0] FcTcpOffset = 5'd17;
    localparam logic [4:0] FcTcpFlags  = 5'd18;

    // classified item from front to back
    typedef struct packed {
        logic        has_field;
        logic [4:0]  code;
        logic [47:0] value;
        logic        last;
        t_status     status;
        logic        tcp_found;
        logic        udp_found;
        logic [15:0] payload_start;
        logic [15:0] payload_bytes;
    } t_item;

    // field lookup: returns {hit, width_bytes[2:0], code[4:0]}
    function automatic logic [8:0] eth_lookup(input logic [15:0] rel);
        case (rel)
            16'd5:   eth_lookup = {1'b1, 3'd6, 5'd0};
            16'd11:  eth_lookup = {1'b1, 3'd6, 5'd1};
            16'd13:  eth_lookup = {1'b1, 3'd2, 5'd2};
            default: eth_lookup = 9'd0;
        endcase
    endfunction

    function automatic logic [8:0] ip_lookup(input logic [15:0] rel);
        case (rel)
            16'd0:   ip_lookup = {1'b1, 3'd1, 5'd3};
            16'd1:   ip_lookup = {1'b1, 3'd1, 5'd4};
            16'd3:   ip_lookup = {1'b1, 3'd2, 5'd5};
            16'd5:   ip_lookup = {1'b1, 3'd2, 5'd6};
            16'd7:   ip_lookup = {1'b1, 3'd2, 5'd7};
            16'd8:   ip_lookup = {1'b1, 3'd1, 5'd8};
            16'd9:   ip_lookup = {1'b1, 3'd1, 5'd9};
            16'd11:  ip_lookup = {1'b1, 3'd2, 5'd10};
            16'd15:  ip_lookup = {1'b1, 3'd4, 5'd11};
            16'd19:  ip_lookup = {1'b1, 3'd4, 5'd12};
            default: ip_lookup = 9'd0;
        endcase
    endfunction

    function automatic logic [8:0] tcp_lookup(input logic [15:0] rel);
        case (rel)
            16'd1:   tcp_lookup = {1'b1, 3'd2, 5'd13};
            16'd3:   tcp_lookup = {1'b1, 3'd2, 5'd14};
            16'd7:   tcp_lookup = {1'b1, 3'd4, 5'd15};
            16'd11:  tcp_lookup = {1'b1, 3'd4, 5'd16};
            16'd12:  tcp_lookup = {1'b1, 3'd1, FcTcpOffset};
            16'd13:  tcp_lookup = {1'b1, 3'd1, FcTcpFlags};
            16'd15:  tcp_lookup = {1'b1, 3'd2, 5'd19};
            16'd17:  tcp_lookup = {1'b1, 3'd2, 5'd20};
            16'd19:  tcp_lookup = {1'b1, 3'd2, 5'd21};
            default: tcp_lookup = 9'd0;
        endcase
    endfunction

    function automatic logic [8:0] udp_lookup(input logic [15:0] rel);
        case (rel)
            16'd1:   udp_lookup = {1'b1, 3'd2, 5'd22};
            16'd3:   udp_lookup = {1'b1, 3'd2, 5'd23};
            16'd5:   udp_lookup = {1'b1, 3'd2, 5'd24};
            16'd7:   udp_lookup = {1'b1, 3'd2, 5'd25};
            default: udp_lookup = 9'd0;
        endcase
    endfunction

    function automatic logic [47:0] take_bytes(input logic [47:0] sh, input logic [2:0] w);
        case (w)
            3'd1:    take_bytes = {40'd0, sh[7:0]};
            3'd2:    take_bytes = {32'd0, sh[15:0]};
            3'd4:    take_bytes = {16'd0, sh[31:0]};
            default: take_bytes = sh;
        endcase
    endfunction

endpackage

// ===== src/ethernet_ipv4_l4_header_parser.sv =====
// ethernet_ipv4_l4_header_parser: top level of the frame header parser
// depends on eihp_pkg, eihp_front, eihp_queue, eihp_back
//
//  channel | direction | handshake            | payload
//  input   | in        | i_valid / o_ready    | i_data_byte, i_last_byte
//  output  | out       | o_valid / i_ready    | record fields (up to two records per byte)
//
// one byte per cycle while the queue has room; a byte that ends a header field
// and the frame yields two records and holds the back end until both are taken
// a record leaves from the queue, which registers the item of its byte
// the front end registers its per-frame state and tracks one accepted byte per cycle
// the queue of QueueDepth entries absorbs output stalls
// reset (synchronous, active low) clears per-frame state, queue and counters
module ethernet_ipv4_l4_header_parser #(
    parameter int MAX_FRAME_BYTES = eihp_pkg::MaxFrameBytesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_record_kind,
    output logic [4:0]  o_field_code,
    output logic [47:0] o_field_value,
    output logic [31:0] o_packet_number,
    output logic [2:0]  o_frame_status,
    output logic        o_tcp_found,
    output logic        o_udp_found,
    output logic [15:0] o_payload_start,
    output logic [15:0] o_payload_bytes,
    output logic [31:0] o_good_frames,
    output logic [31:0] o_bad_frames,
    output logic        o_end_of_run
);

    // front to queue
    logic            fq_valid, fq_ready;
    eihp_pkg::t_item fq_item;
    // queue to back
    logic            qb_valid, qb_ready;
    eihp_pkg::t_item qb_item;

    eihp_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(i_valid), .o_ready(o_ready),
        .i_data_byte, .i_last_byte,
        .o_valid(fq_valid), .i_ready(fq_ready), .o_item(fq_item)
    );

    eihp_queue #(.DEPTH(eihp_pkg::QueueDepth)) u_queue (
        .i_clk, .i_rst_n,
        .i_valid(fq_valid), .o_ready(fq_ready), .i_item(fq_item),
        .o_valid(qb_valid), .i_ready(qb_ready), .o_item(qb_item)
    );

    eihp_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(qb_valid), .o_ready(qb_ready), .i_item(qb_item),
        .o_valid, .i_ready,
        .o_record_kind, .o_field_code, .o_field_value, .o_packet_number,
        .o_frame_status, .o_tcp_found, .o_udp_found, .o_payload_start,
        .o_payload_bytes, .o_good_frames, .o_bad_frames, .o_end_of_run
    );

    // a field record never carries summary data
    a_field_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_record_kind |->
            o_frame_status == eihp_pkg::ST_OK && !o_tcp_found && !o_udp_found)
        else $error("field record carries summary data");

    // a summary record always ends the run
    a_summary_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_record_kind |-> o_end_of_run)
        else $error("summary record without end of run");

    // the packet id advances right after a summary is taken
    a_pkt_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_record_kind |=> o_packet_number == $past(o_packet_number) + 32'd1)
        else $error("packet id did not advance");

    // found flags only with ok status
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_tcp_found || o_udp_found) |-> o_frame_status == eihp_pkg::ST_OK)
        else $error("found flag with error status");

endmodule

// ===== src/eihp_front.sv =====
// eihp_front: per-byte header tracking and field classification
// depends on eihp_pkg
module eihp_front #(
    parameter int MAX_FRAME_BYTES = eihp_pkg::MaxFrameBytesDefault
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_data_byte,
    input  logic           i_last_byte,
    output logic           o_valid,
    input  logic           i_ready,
    output eihp_pkg::t_item o_item
);

    localparam logic [16:0] MaxLen = 17'(MAX_FRAME_BYTES);

    logic [15:0] r_pos;
    logic [47:0] r_shift;
    logic        r_ip_ok;
    logic [1:0]  r_herr;
    logic [3:0]  r_ihl;
    logic [7:0]  r_proto;
    logic [3:0]  r_tcp_wc;

    logic [15:0] n_pos;
    logic [47:0] n_shift;
    logic        n_ip_ok;
    logic [1:0]  n_herr;
    logic [3:0]  n_ihl;
    logic [7:0]  n_proto;
    logic [3:0]  n_tcp_wc;

    logic        accept;
    logic [16:0] tstart, len, trel;
    logic [15:0] rel;
    logic [8:0]  lk;
    logic        l4_on;
    eihp_pkg::t_item item;

    assign o_ready = i_ready;
    assign o_valid = i_valid;
    assign accept  = i_valid && i_ready;
    assign o_item  = item;

    always_comb begin
        n_shift  = {r_shift[39:0], i_data_byte};
        n_pos    = r_pos;
        n_ip_ok  = r_ip_ok;
        n_herr   = r_herr;
        n_ihl    = r_ihl;
        n_proto  = r_proto;
        n_tcp_wc = r_tcp_wc;
        tstart   = 17'd14 + {11'd0, r_ihl, 2'b00};
        len      = {1'b0, r_pos} + 17'd1;
        trel     = {1'b0, r_pos} - tstart;
        rel      = trel[15:0];
        lk       = 9'd0;
        item     = '0;
        item.last = i_last_byte;
        if (r_pos < 16'd14) begin
            lk = eihp_pkg::eth_lookup(r_pos);
            if (r_pos == 16'd13 && n_shift[15:0] != eihp_pkg::EthertypeIpv4) begin
                n_herr = eihp_pkg::HE_NOT_IPV4;
            end
        end else if (r_pos < 16'd34) begin
            if (r_pos == 16'd14 && r_herr == eihp_pkg::HE_NONE) begin
                if (i_data_byte[7:4] == 4'd4) begin
                    n_ip_ok = 1'b1;
                    n_ihl   = i_data_byte[3:0];
                    if (i_data_byte[3:0] < 4'd5) begin
                        n_herr = eihp_pkg::HE_BAD_IP;
                    end
                end else begin
                    n_herr = eihp_pkg::HE_BAD_IP;
                end
            end
            if (n_ip_ok) begin
                if (r_pos == 16'd23) begin
                    n_proto = i_data_byte;
                end
                lk = eihp_pkg::ip_lookup(r_pos - 16'd14);
            end
        end
        // transport stage uses state as of this byte's start (ihl fixed by then)
        l4_on = r_ip_ok && r_herr == eihp_pkg::HE_NONE && {1'b0, r_pos} >= tstart;
        if (l4_on && r_proto == eihp_pkg::ProtoTcp && trel < 17'd20) begin
            if (rel == 16'd12) begin
                n_tcp_wc = i_data_byte[7:4];
            end
            lk = eihp_pkg::tcp_lookup(rel);
        end else if (l4_on && r_proto == eihp_pkg::ProtoUdp && trel < 17'd8) begin
            lk = eihp_pkg::udp_lookup(rel);
        end
        item.has_field = lk[8];
        item.code      = lk[4:0];
        if (lk[4:0] == eihp_pkg::FcTcpOffset && lk[8] && l4_on) begin
            item.value = {44'd0, i_data_byte[7:4]};
        end else if (lk[4:0] == eihp_pkg::FcTcpFlags && lk[8] && l4_on) begin
            item.value = {42'd0, i_data_byte[5:0]};
        end else begin
            item.value = eihp_pkg::take_bytes(n_shift, lk[7:5]);
        end

        // summary
        if (len < {1'b0, eihp_pkg::MinFrameLen}) begin
            item.status = eihp_pkg::ST_SHORT;
        end else if (len > MaxLen) begin
            item.status = eihp_pkg::ST_TOO_LONG;
        end else if (n_herr == eihp_pkg::HE_NOT_IPV4) begin
            item.status = eihp_pkg::ST_NOT_IPV4;
        end else if (n_herr == eihp_pkg::HE_BAD_IP) begin
            item.status = eihp_pkg::ST_BAD_IP;
        end else begin
            item.status = eihp_pkg::ST_OK;
        end
        // data offset is used as given, even below five
        if (item.status == eihp_pkg::ST_OK) begin
            if (n_proto == eihp_pkg::ProtoTcp && len >= tstart + 17'd20) begin
                item.tcp_found = 1'b1;
                if (len - tstart > {11'd0, n_tcp_wc, 2'b00}) begin
                    item.payload_start = 16'(tstart + {11'd0, n_tcp_wc, 2'b00});
                    item.payload_bytes = 16'(len - tstart - {11'd0, n_tcp_wc, 2'b00});
                end
            end else if (n_proto == eihp_pkg::ProtoUdp && len >= tstart + 17'd8) begin
                item.udp_found = 1'b1;
                if (len - tstart > 17'd8) begin
                    item.payload_start = 16'(tstart + 17'd8);
                    item.payload_bytes = 16'(len - tstart - 17'd8);
                end
            end
        end
        if (i_last_byte) begin
            n_pos = '0; n_shift = '0; n_ip_ok = 1'b0; n_herr = '0;
            n_ihl = '0; n_proto = '0; n_tcp_wc = '0;
        end else if (r_pos != 16'hFFFF) begin
            n_pos = r_pos + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_shift <= '0; r_ip_ok <= 1'b0; r_herr <= '0;
            r_ihl <= '0; r_proto <= '0; r_tcp_wc <= '0;
        end else if (accept) begin
            r_pos <= n_pos; r_shift <= n_shift; r_ip_ok <= n_ip_ok; r_herr <= n_herr;
            r_ihl <= n_ihl; r_proto <= n_proto; r_tcp_wc <= n_tcp_wc;
        end
    end

endmodule

// ===== src/eihp_queue.sv =====
// eihp_queue: small fifo of classified items between front and back
// depends on eihp_pkg
module eihp_queue #(
    parameter int DEPTH = eihp_pkg::QueueDepth
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  eihp_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output eihp_pkg::t_item o_item
);

    localparam int AW = $clog2(DEPTH);

    eihp_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic push, pop;

    assign o_ready = r_cnt != (AW+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

// ===== src/eihp_back.sv =====
// eihp_back: expands items into field and summary records, keeps counters
// depends on eihp_pkg
module eihp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  eihp_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_record_kind,
    output logic [4:0]     o_field_code,
    output logic [47:0]    o_field_value,
    output logic [31:0]    o_packet_number,
    output logic [2:0]     o_frame_status,
    output logic           o_tcp_found,
    output logic           o_udp_found,
    output logic [15:0]    o_payload_start,
    output logic [15:0]    o_payload_bytes,
    output logic [31:0]    o_good_frames,
    output logic [31:0]    o_bad_frames,
    output logic           o_end_of_run
);

    logic        r_field_done;  // field record of head item already sent
    logic [31:0] r_frame, r_good, r_bad;
    logic        send_field, rec_take, item_done;

    assign send_field = i_item.has_field && !r_field_done;
    assign o_valid    = i_valid && (send_field || i_item.last);
    assign rec_take   = o_valid && i_ready;
    assign item_done  = i_valid && (!(send_field || i_item.last) ||
                        (rec_take && !(send_field && i_item.last)));
    assign o_ready    = item_done;

    always_comb begin
        o_record_kind   = !send_field;
        o_field_code    = send_field ? i_item.code : 5'd0;
        o_field_value   = send_field ? i_item.value : 48'd0;
        o_packet_number = r_frame;
        o_frame_status  = send_field ? eihp_pkg::ST_OK : i_item.status;
        o_tcp_found     = !send_field && i_item.tcp_found;
        o_udp_found     = !send_field && i_item.udp_found;
        o_payload_start = send_field ? 16'd0 : i_item.payload_start;
        o_payload_bytes = send_field ? 16'd0 : i_item.payload_bytes;
        o_good_frames   = 32'd0;
        o_bad_frames    = 32'd0;
        if (!send_field) begin
            o_good_frames = r_good + 32'((i_item.status == eihp_pkg::ST_OK) ? 1 : 0);
            o_bad_frames  = r_bad  + 32'((i_item.status != eihp_pkg::ST_OK) ? 1 : 0);
        end
        o_end_of_run    = !(send_field && i_item.last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_done <= 1'b0;
            r_frame <= 32'd1; r_good <= '0; r_bad <= '0;
        end else begin
            if (item_done) begin
                r_field_done <= 1'b0;
            end else if (rec_take && send_field) begin
                r_field_done <= 1'b1;
            end
            if (rec_take && !send_field) begin
                r_frame <= r_frame + 32'd1;
                r_good <= o_good_frames;
                r_bad  <= o_bad_frames;
            end
        end
    end

endmodule

// ===== sim/header_record_checker.sv =====
// header_record_checker: predicts parser records from accepted frame bytes and compares them
// depends on eihp_pkg for status codes and the protocol constants
`timescale 1ns / 1ps

module header_record_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_o_valid,
    input  logic        i_ready,
    input  logic        i_record_kind,
    input  logic [4:0]  i_field_code,
    input  logic [47:0] i_field_value,
    input  logic [31:0] i_packet_number,
    input  logic [2:0]  i_frame_status,
    input  logic        i_tcp_found,
    input  logic        i_udp_found,
    input  logic [15:0] i_payload_start,
    input  logic [15:0] i_payload_bytes,
    input  logic [31:0] i_good_frames,
    input  logic [31:0] i_bad_frames,
    input  logic        i_end_of_run,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic        kind;
        logic [4:0]  code;
        logic [47:0] value;
        logic [31:0] pkt;
        logic [2:0]  status;
        logic        tcpf;
        logic        udpf;
        logic [15:0] pstart;
        logic [15:0] pbytes;
        logic [31:0] good;
        logic [31:0] bad;
        logic        eor;
    } t_record;

    t_record          expected_records[$];
    logic [15:0]      pos_q;
    logic [47:0]      shift_q;
    logic             ip_ok;
    eihp_pkg::t_herr  herr;
    logic [3:0]       ihl;
    logic [7:0]       proto;
    logic [3:0]       doff;
    logic [31:0]      frame_id, n_good, n_bad;

    // returns width in bytes and code for a field that ends at rel, width 0 if none
    function automatic void field_end(input int tab, input int rel, output int w, output int c);
        w = 0;
        c = 0;
        case (tab)
            0: case (rel)
                5: begin w = 6; c = 0; end
                11: begin w = 6; c = 1; end
                13: begin w = 2; c = 2; end
                default: ;
            endcase
            1: case (rel)
                0: begin w = 1; c = 3; end
                1: begin w = 1; c = 4; end
                3: begin w = 2; c = 5; end
                5: begin w = 2; c = 6; end
                7: begin w = 2; c = 7; end
                8: begin w = 1; c = 8; end
                9: begin w = 1; c = 9; end
                11: begin w = 2; c = 10; end
                15: begin w = 4; c = 11; end
                19: begin w = 4; c = 12; end
                default: ;
            endcase
            2: case (rel)
                1: begin w = 2; c = 13; end
                3: begin w = 2; c = 14; end
                7: begin w = 4; c = 15; end
                11: begin w = 4; c = 16; end
                12: begin w = 1; c = 17; end
                13: begin w = 1; c = 18; end
                15: begin w = 2; c = 19; end
                17: begin w = 2; c = 20; end
                19: begin w = 2; c = 21; end
                default: ;
            endcase
            default: case (rel)
                1: begin w = 2; c = 22; end
                3: begin w = 2; c = 23; end
                5: begin w = 2; c = 24; end
                7: begin w = 2; c = 25; end
                default: ;
            endcase
        endcase
    endfunction

    function automatic logic [47:0] low_bytes(input logic [47:0] v, input int w);
        return (w >= 6) ? v : (v & ((48'd1 << (8 * w)) - 48'd1));
    endfunction

    task automatic predict_byte(input logic [7:0] b, input logic last);
        int      p, ts, w, c, code, len, rel;
        logic [47:0] val;
        t_record r;
        eihp_pkg::t_status st;
        logic    on;
        p = pos_q;
        ts = 14 + ihl * 4;
        code = -1;
        val = '0;
        shift_q = {shift_q[39:0], b};
        if (p < 14) begin
            field_end(0, p, w, c);
            if (w > 0) begin code = c; val = low_bytes(shift_q, w); end
            if (p == 13 && shift_q[15:0] != eihp_pkg::EthertypeIpv4) herr = eihp_pkg::HE_NOT_IPV4;
        end else if (p < 34) begin
            if (p == 14 && herr == eihp_pkg::HE_NONE) begin
                if (b[7:4] == 4'd4) begin
                    ip_ok = 1'b1;
                    ihl = b[3:0];
                    if (b[3:0] < 4'd5) herr = eihp_pkg::HE_BAD_IP;
                end else begin
                    herr = eihp_pkg::HE_BAD_IP;
                end
            end
            if (ip_ok) begin
                if (p == 23) proto = b;
                field_end(1, p - 14, w, c);
                if (w > 0) begin code = c; val = low_bytes(shift_q, w); end
            end
        end
        on = ip_ok && herr == eihp_pkg::HE_NONE && p >= ts;
        rel = p - ts;
        if (on && proto == eihp_pkg::ProtoTcp && rel < 20) begin
            if (rel == 12) doff = b[7:4];
            field_end(2, rel, w, c);
            if (w > 0) begin
                code = c;
                if (rel == 12) val = {44'd0, b[7:4]};
                else if (rel == 13) val = {42'd0, b[5:0]};
                else val = low_bytes(shift_q, w);
            end
        end else if (on && proto == eihp_pkg::ProtoUdp && rel < 8) begin
            field_end(3, rel, w, c);
            if (w > 0) begin code = c; val = low_bytes(shift_q, w); end
        end
        if (code >= 0) begin
            r = '0;
            r.code = code[4:0];
            r.value = val;
            r.pkt = frame_id;
            r.eor = !last;
            expected_records.push_back(r);
        end
        if (last) begin
            len = p + 1;
            r = '0;
            if (len < 34) st = eihp_pkg::ST_SHORT;
            else if (len > eihp_pkg::MaxFrameBytesDefault) st = eihp_pkg::ST_TOO_LONG;
            else if (herr == eihp_pkg::HE_NOT_IPV4) st = eihp_pkg::ST_NOT_IPV4;
            else if (herr == eihp_pkg::HE_BAD_IP) st = eihp_pkg::ST_BAD_IP;
            else st = eihp_pkg::ST_OK;
            if (st == eihp_pkg::ST_OK) begin
                if (proto == eihp_pkg::ProtoTcp && len >= ts + 20) begin
                    r.tcpf = 1'b1;
                    if (len - ts > doff * 4) begin
                        r.pstart = 16'(ts + doff * 4);
                        r.pbytes = 16'(len - ts - doff * 4);
                    end
                end else if (proto == eihp_pkg::ProtoUdp && len >= ts + 8) begin
                    r.udpf = 1'b1;
                    if (len - ts > 8) begin
                        r.pstart = 16'(ts + 8);
                        r.pbytes = 16'(len - ts - 8);
                    end
                end
                n_good++;
            end else begin
                n_bad++;
            end
            r.kind = 1'b1;
            r.pkt = frame_id;
            r.status = st;
            r.good = n_good;
            r.bad = n_bad;
            r.eor = 1'b1;
            expected_records.push_back(r);
            frame_id++;
            pos_q = '0;
            shift_q = '0;
            ip_ok = 1'b0;
            herr = eihp_pkg::HE_NONE;
            ihl = '0;
            proto = '0;
            doff = '0;
        end else if (pos_q != 16'hFFFF) begin
            pos_q++;
        end
    endtask

    always @(posedge i_clk) begin
        t_record a, e;
        if (!i_rst_n) begin
            expected_records.delete();
            pos_q = '0;
            shift_q = '0;
            ip_ok = 1'b0;
            herr = eihp_pkg::HE_NONE;
            ihl = '0;
            proto = '0;
            doff = '0;
            frame_id = 32'd1;
            n_good = '0;
            n_bad = '0;
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_o_valid && i_ready) begin
                a = {i_record_kind, i_field_code, i_field_value, i_packet_number,
                     i_frame_status, i_tcp_found, i_udp_found, i_payload_start,
                     i_payload_bytes, i_good_frames, i_bad_frames, i_end_of_run};
                if (expected_records.size() == 0) begin
                    $display("%0t unexpected record %h", $time, a);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = expected_records.pop_front();
                    if (a !== e) begin
                        $display("%0t record mismatch expected %h actual %h", $time, e, a);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            // prediction after the compare so a same-edge byte cannot overtake
            if (i_valid && i_o_ready) predict_byte(i_data_byte, i_last_byte);
            o_pending <= expected_records.size();
        end
    end

    initial o_fail_count = 0;
    initial o_pending = 0;
endmodule

// ===== sim/testbench.sv =====
// testbench: drives frames into the header parser and gives the verdict
// depends on eihp_pkg, ethernet_ipv4_l4_header_parser and header_record_checker
`timescale 1ns / 1ps

module testbench;

    localparam int StallLimit = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_record_kind;
    logic [4:0]  o_field_code;
    logic [47:0] o_field_value;
    logic [31:0] o_packet_number;
    logic [2:0]  o_frame_status;
    logic        o_tcp_found;
    logic        o_udp_found;
    logic [15:0] o_payload_start;
    logic [15:0] o_payload_bytes;
    logic [31:0] o_good_frames;
    logic [31:0] o_bad_frames;
    logic        o_end_of_run;
    int          fail_count;
    int          pending;

    // idle percentages per side, changed between phases
    int send_idle_pct = 21;
    int recv_idle_pct = 56;
    int hold_cycles = 0;     // long receiver hold-off
    int idle_cycles = 0;     // watchdog count

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    ethernet_ipv4_l4_header_parser u_dut (.*);

    header_record_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_o_ready(o_ready), .i_data_byte, .i_last_byte,
        .i_o_valid(o_valid), .i_ready,
        .i_record_kind(o_record_kind), .i_field_code(o_field_code),
        .i_field_value(o_field_value), .i_packet_number(o_packet_number),
        .i_frame_status(o_frame_status), .i_tcp_found(o_tcp_found),
        .i_udp_found(o_udp_found), .i_payload_start(o_payload_start),
        .i_payload_bytes(o_payload_bytes), .i_good_frames(o_good_frames),
        .i_bad_frames(o_bad_frames), .i_end_of_run(o_end_of_run),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver: random ready, with an optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog: cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > StallLimit) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    logic [7:0] frame_bytes[$];
    int         items_sent = 0;

    // offers one byte, holding it until taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_frame();
        int n;
        n = frame_bytes.size();
        for (int i = 0; i < n; i++) send_byte(frame_bytes[i], i == n - 1);
        i_valid <= 1'b0;
    endtask

    // builds a frame: kind 0 tcp, 1 udp, 2 other proto, 3 non-ip, 4 bad version/ihl
    task automatic build_frame(input int kind, input int ihl, input int doff, input int len);
        frame_bytes.delete();
        for (int i = 0; i < len; i++) frame_bytes.push_back(8'($urandom_range(255)));
        if (len > 13 && kind != 3) begin
            frame_bytes[12] = 8'h08;
            frame_bytes[13] = 8'h00;
        end
        if (len > 14) frame_bytes[14] = (kind == 4) ? 8'($urandom_range(255)) : {4'd4, ihl[3:0]};
        if (len > 23) frame_bytes[23] = (kind == 0) ? eihp_pkg::ProtoTcp :
                                        (kind == 1) ? eihp_pkg::ProtoUdp : frame_bytes[23];
        if (len > 14 + ihl * 4 + 12) frame_bytes[14 + ihl * 4 + 12][7:4] = doff[3:0];
    endtask

    task automatic random_frame();
        int kind, ihl, len, r;
        r = $urandom_range(99);
        kind = (r < 40) ? 0 : (r < 75) ? 1 : (r < 82) ? 2 : (r < 90) ? 3 : 4;
        ihl = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(5, 7);
        len = ($urandom_range(7) == 0) ? $urandom_range(1, 40) : $urandom_range(34, 80);
        build_frame(kind, ihl, $urandom_range(15), len);
        send_frame();
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: tcp, udp, short headers, other proto, non-ip, bad versions
        build_frame(0, 5, 5, 60);   send_frame();
        build_frame(1, 5, 0, 50);   send_frame();
        build_frame(0, 6, 2, 64);   send_frame();
        build_frame(0, 5, 15, 54);  send_frame();
        build_frame(1, 5, 0, 40);   send_frame();
        build_frame(0, 5, 5, 40);   send_frame();
        build_frame(2, 5, 0, 40);   send_frame();
        build_frame(3, 5, 0, 40);   send_frame();
        build_frame(0, 3, 5, 60);   send_frame();
        build_frame(4, 5, 5, 40);   send_frame();
        build_frame(0, 5, 5, 1);    send_frame();
        build_frame(1, 5, 0, 33);   send_frame();
        build_frame(1, 15, 0, 34);  send_frame();
        frame_bytes = '{8'hFF, 8'h00};
        send_frame();
        // long receiver hold-off while bytes keep coming
        hold_cycles = 200;
        build_frame(0, 5, 5, 60);   send_frame();
        drain();
        send_idle_pct = 21;
        recv_idle_pct = 56;
        while (items_sent < 830) random_frame();
        send_idle_pct = 56;
        recv_idle_pct = 21;
        while (items_sent < 1040) random_frame();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (items_sent < 1250) random_frame();
        drain();
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ===== files.f =====
src/eihp_pkg.sv
src/eihp_front.sv
src/eihp_queue.sv
src/eihp_back.sv
src/ethernet_ipv4_l4_header_parser.sv
sim/header_record_checker.sv
sim/testbench.sv
